FILE: sv/three_level_priority_fifo_table_unit_defines.svh
// Assertion macros shared by the RTL.
`ifndef THREE_LEVEL_PRIORITY_FIFO_TABLE_UNIT_DEFINES_SVH
`define THREE_LEVEL_PRIORITY_FIFO_TABLE_UNIT_DEFINES_SVH

// Same-cycle implication.
`define TLPF_ASSERT_NOW(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("tlpf check failed");

// Next-cycle implication.
`define TLPF_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("tlpf check failed");

`endif

FILE: sv/tlpf_pkg.sv
package tlpf_pkg;

   localparam int CMD_BITS    = 2;
   localparam int PRIO_BITS   = 2;
   localparam int STATUS_BITS = 3;

   localparam logic [CMD_BITS-1:0] CMD_INSERT   = 2'd0;
   localparam logic [CMD_BITS-1:0] CMD_SET_PRIO = 2'd1;
   localparam logic [CMD_BITS-1:0] CMD_SERVE    = 2'd2;

   localparam logic [PRIO_BITS-1:0] PRIO_LOW     = 2'd2;
   localparam logic [PRIO_BITS-1:0] PRIO_INVALID = 2'd3;

   localparam logic [STATUS_BITS-1:0] STATUS_OK        = 3'd0;
   localparam logic [STATUS_BITS-1:0] STATUS_EMPTY     = 3'd1;
   localparam logic [STATUS_BITS-1:0] STATUS_NOT_FOUND = 3'd2;
   localparam logic [STATUS_BITS-1:0] STATUS_BAD_PRIO  = 3'd3;
   localparam logic [STATUS_BITS-1:0] STATUS_FULL      = 3'd4;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_FINISH
   } state_type;

endpackage

FILE: sv/three_level_priority_fifo_table_unit.sv
// Three-level priority table with first-come tie break.
//
// Input channel (req_*): one command word per item. Insert puts req_entry_key
// in the lowest free slot at low priority; set priority changes the oldest
// entry with that key; serve removes the best-priority, oldest entry.
// Result channel (rsp_*): exactly one word per command with status, the
// served key and priority (zero unless a serve succeeds) and occupancy.
//
// Timing: every command walks all ENTRIES slots through one RAM read port
// and one age subtract/compare unit, one slot per cycle. From accept, a
// command runs through the scan and the write-back step into the result
// register, and the block goes back to idle before req_ready rises again, so
// it takes no new command until the last one has been written back.
// A finished result waits in the rsp register; the next command is taken
// while it waits. If the receiver stalls long enough for that next command to
// finish too, the block holds in its write-back step until the rsp register
// frees up.
// Reset (synchronous, active high) empties the table, zeroes the arrival
// counter and drops rsp_valid. Slot contents are not cleared; no slot's contents
// are used before it is written.
`include "three_level_priority_fifo_table_unit_defines.svh"

module three_level_priority_fifo_table_unit #(
   parameter int ENTRIES    = 16,
   parameter int KEY_BITS   = 16,
   parameter int STAMP_BITS = 32
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic [tlpf_pkg::CMD_BITS-1:0]        req_cmd,
   input  logic [KEY_BITS-1:0]                  req_entry_key,
   input  logic [tlpf_pkg::PRIO_BITS-1:0]       req_new_priority,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic [tlpf_pkg::STATUS_BITS-1:0]     rsp_status,
   output logic [KEY_BITS-1:0]                  rsp_served_key,
   output logic [tlpf_pkg::PRIO_BITS-1:0]       rsp_served_priority,
   output logic [$clog2(ENTRIES+1)-1:0]         rsp_occupancy
);

   import tlpf_pkg::*;

   localparam int IDX_BITS  = $clog2(ENTRIES);
   localparam int LIVE_BITS = $clog2(ENTRIES + 1);
   localparam int WORD_BITS = KEY_BITS + PRIO_BITS + STAMP_BITS;
   localparam logic [IDX_BITS-1:0] LAST_IDX = IDX_BITS'(ENTRIES - 1);

   // control state
   state_type               state_ff, state_in;
   logic [ENTRIES-1:0]      slot_valid_ff, slot_valid_in;
   logic [STAMP_BITS-1:0]   arrival_counter_ff, arrival_counter_in;
   logic [LIVE_BITS-1:0]    live_count_ff, live_count_in;
   logic                    issuing_ff, issuing_in;
   logic                    cmp_vld_ff, cmp_vld_in;
   logic                    found_ff, found_in;
   logic                    rsp_valid_ff, rsp_valid_in;

   // payload
   logic [CMD_BITS-1:0]     cmd_ff, cmd_in;
   logic [KEY_BITS-1:0]     key_ff, key_in;
   logic [PRIO_BITS-1:0]    prio_ff, prio_in;
   logic [IDX_BITS-1:0]     issue_idx_ff, issue_idx_in;
   logic [IDX_BITS-1:0]     cmp_idx_ff, cmp_idx_in;
   logic [IDX_BITS-1:0]     best_idx_ff, best_idx_in;
   logic [KEY_BITS-1:0]     best_key_ff, best_key_in;
   logic [PRIO_BITS-1:0]    best_prio_ff, best_prio_in;
   logic [STAMP_BITS-1:0]   best_stamp_ff, best_stamp_in;
   logic [STAMP_BITS-1:0]   best_age_ff, best_age_in;
   logic [STATUS_BITS-1:0]  rsp_status_ff, rsp_status_in;
   logic [KEY_BITS-1:0]     rsp_key_ff, rsp_key_in;
   logic [PRIO_BITS-1:0]    rsp_prio_ff, rsp_prio_in;
   logic [LIVE_BITS-1:0]    rsp_occ_ff, rsp_occ_in;

   // slot RAM: {key, priority, stamp}
   logic                    ram_wr_en;
   logic [IDX_BITS-1:0]     ram_wr_addr;
   logic [WORD_BITS-1:0]    ram_wr_data;
   logic [WORD_BITS-1:0]    ram_rd_data;
   logic [KEY_BITS-1:0]     rd_key;
   logic [PRIO_BITS-1:0]    rd_prio;
   logic [STAMP_BITS-1:0]   rd_stamp;
   logic [STAMP_BITS-1:0]   rd_age;
   logic                    rd_slot_valid;
   logic                    take;
   logic                    rsp_free;
   logic                    ctr_adv;

   tlpf_ram #(
      .WIDTH (WORD_BITS),
      .DEPTH (ENTRIES)
   ) u_slot_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_addr (issue_idx_ff),
      .rd_data (ram_rd_data)
   );

   assign rd_key        = ram_rd_data[WORD_BITS-1 -: KEY_BITS];
   assign rd_prio       = ram_rd_data[STAMP_BITS +: PRIO_BITS];
   assign rd_stamp      = ram_rd_data[STAMP_BITS-1:0];
   // the one shared age subtractor: modular age of the slot under compare
   assign rd_age        = arrival_counter_ff - rd_stamp;
   assign rd_slot_valid = slot_valid_ff[cmp_idx_ff];
   assign rsp_free      = !rsp_valid_ff || rsp_ready;

   // candidate test for the slot under compare
   always_comb begin
      take = 1'b0;
      case (cmd_ff)
         CMD_INSERT: begin
            take = !found_ff && !rd_slot_valid;
         end
         CMD_SET_PRIO: begin
            take = rd_slot_valid && (rd_key == key_ff) &&
                   (!found_ff || (rd_age > best_age_ff));
         end
         CMD_SERVE: begin
            take = rd_slot_valid && (!found_ff || (rd_prio < best_prio_ff) ||
                   ((rd_prio == best_prio_ff) && (rd_age > best_age_ff)));
         end
         default: begin
            take = 1'b0;
         end
      endcase
   end

   // sequencer: next state, datapath updates, write-back
   always_comb begin
      state_in           = state_ff;
      slot_valid_in      = slot_valid_ff;
      arrival_counter_in = arrival_counter_ff;
      live_count_in      = live_count_ff;
      issuing_in         = issuing_ff;
      cmp_vld_in         = 1'b0;
      found_in           = found_ff;
      rsp_valid_in       = rsp_valid_ff && !rsp_ready;
      cmd_in             = cmd_ff;
      key_in             = key_ff;
      prio_in            = prio_ff;
      issue_idx_in       = issue_idx_ff;
      cmp_idx_in         = cmp_idx_ff;
      best_idx_in        = best_idx_ff;
      best_key_in        = best_key_ff;
      best_prio_in       = best_prio_ff;
      best_stamp_in      = best_stamp_ff;
      best_age_in        = best_age_ff;
      rsp_status_in      = rsp_status_ff;
      rsp_key_in         = rsp_key_ff;
      rsp_prio_in        = rsp_prio_ff;
      rsp_occ_in         = rsp_occ_ff;
      req_ready          = 1'b0;
      ram_wr_en          = 1'b0;
      ram_wr_addr        = best_idx_ff;
      ram_wr_data        = {best_key_ff, prio_ff, best_stamp_ff};
      ctr_adv            = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd_in       = req_cmd;
               key_in       = req_entry_key;
               prio_in      = req_new_priority;
               issue_idx_in = '0;
               issuing_in   = 1'b1;
               found_in     = 1'b0;
               state_in     = ST_SCAN;
            end
         end
         ST_SCAN: begin
            // read issue stage
            if (issuing_ff) begin
               cmp_vld_in = 1'b1;
               cmp_idx_in = issue_idx_ff;
               if (issue_idx_ff == LAST_IDX) begin
                  issuing_in = 1'b0;
               end else begin
                  issue_idx_in = issue_idx_ff + 1'b1;
               end
            end
            // compare stage, one slot behind
            if (cmp_vld_ff) begin
               if (take) begin
                  found_in      = 1'b1;
                  best_idx_in   = cmp_idx_ff;
                  best_key_in   = rd_key;
                  best_prio_in  = rd_prio;
                  best_stamp_in = rd_stamp;
                  best_age_in   = rd_age;
               end
               if (cmp_idx_ff == LAST_IDX) begin
                  state_in = ST_FINISH;
               end
            end
         end
         ST_FINISH: begin
            if (rsp_free) begin
               rsp_status_in = STATUS_OK;
               rsp_key_in    = '0;
               rsp_prio_in   = '0;
               case (cmd_ff)
                  CMD_INSERT: begin
                     if (found_ff) begin
                        ram_wr_en                  = 1'b1;
                        ram_wr_data                = {key_ff, PRIO_LOW, arrival_counter_ff};
                        slot_valid_in[best_idx_ff] = 1'b1;
                        arrival_counter_in         = arrival_counter_ff + 1'b1;
                        live_count_in              = live_count_ff + 1'b1;
                        ctr_adv                    = 1'b1;
                     end else begin
                        rsp_status_in = STATUS_FULL;
                     end
                  end
                  CMD_SET_PRIO: begin
                     // key check ranks above the code check
                     if (!found_ff) begin
                        rsp_status_in = STATUS_NOT_FOUND;
                     end else if (prio_ff == PRIO_INVALID) begin
                        rsp_status_in = STATUS_BAD_PRIO;
                     end else begin
                        ram_wr_en = 1'b1;
                     end
                  end
                  CMD_SERVE: begin
                     if (found_ff) begin
                        slot_valid_in[best_idx_ff] = 1'b0;
                        live_count_in              = live_count_ff - 1'b1;
                        rsp_key_in                 = best_key_ff;
                        rsp_prio_in                = best_prio_ff;
                     end else begin
                        rsp_status_in = STATUS_EMPTY;
                     end
                  end
                  default: begin
                     // unused command: no change, status ok
                  end
               endcase
               rsp_occ_in   = live_count_in;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slot_valid_ff      <= '0;
         arrival_counter_ff <= '0;
         live_count_ff      <= '0;
         issuing_ff         <= 1'b0;
         cmp_vld_ff         <= 1'b0;
         found_ff           <= 1'b0;
         rsp_valid_ff       <= 1'b0;
      end else begin
         slot_valid_ff      <= slot_valid_in;
         arrival_counter_ff <= arrival_counter_in;
         live_count_ff      <= live_count_in;
         issuing_ff         <= issuing_in;
         cmp_vld_ff         <= cmp_vld_in;
         found_ff           <= found_in;
         rsp_valid_ff       <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff        <= cmd_in;
      key_ff        <= key_in;
      prio_ff       <= prio_in;
      issue_idx_ff  <= issue_idx_in;
      cmp_idx_ff    <= cmp_idx_in;
      best_idx_ff   <= best_idx_in;
      best_key_ff   <= best_key_in;
      best_prio_ff  <= best_prio_in;
      best_stamp_ff <= best_stamp_in;
      best_age_ff   <= best_age_in;
      rsp_status_ff <= rsp_status_in;
      rsp_key_ff    <= rsp_key_in;
      rsp_prio_ff   <= rsp_prio_in;
      rsp_occ_ff    <= rsp_occ_in;
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_status          = rsp_status_ff;
   assign rsp_served_key      = rsp_key_ff;
   assign rsp_served_priority = rsp_prio_ff;
   assign rsp_occupancy       = rsp_occ_ff;

   // occupancy count tracks the valid bits
   `TLPF_ASSERT_NOW(a_live_matches_valid, clock, reset, 1'b1, live_count_ff == $countones(slot_valid_ff))
   // arrival counter moves only on a successful insert
   `TLPF_ASSERT_NEXT(a_counter_hold, clock, reset, !ctr_adv, arrival_counter_ff == $past(arrival_counter_ff))
   // a result appears only out of the write-back step
   `TLPF_ASSERT_NEXT(a_rsp_source, clock, reset, !rsp_valid_ff && !((state_ff == ST_FINISH) && rsp_free), !rsp_valid_ff)
   // no slot state changes while the scan is running
   `TLPF_ASSERT_NEXT(a_scan_no_write, clock, reset, state_ff == ST_SCAN, slot_valid_ff == $past(slot_valid_ff))

endmodule

FILE: sv/tlpf_ram.sv
module tlpf_ram #(
   parameter int WIDTH = 50,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: tb/tb_three_level_priority_fifo_table_unit.sv
`timescale 1ns / 1ps

module tb_three_level_priority_fifo_table_unit;
   import tlpf_pkg::*;

   localparam int NUM_SLOTS  = 16;
   localparam int KEY_W      = 16;
   localparam int STAMP_W    = 32;
   localparam int OCC_W      = $clog2(NUM_SLOTS + 1);
   localparam int HALF_CLK   = 4;
   localparam int MAX_REPORT = 10;

   // cmd 3 has no package name; the block must treat it as a no-op
   localparam logic [CMD_BITS-1:0]  CMD_UNUSED   = 2'd3;
   localparam logic [PRIO_BITS-1:0] TB_PRIO_HIGH = 2'd0;
   localparam logic [PRIO_BITS-1:0] TB_PRIO_MED  = 2'd1;

   typedef struct packed {
      logic [STATUS_BITS-1:0] status;
      logic [KEY_W-1:0]       key;
      logic [PRIO_BITS-1:0]   level;
      logic [OCC_W-1:0]       occ;
   } reply_type;

   // ---------------------------------------------------------------------
   // clock, reset, DUT
   // ---------------------------------------------------------------------
   logic                   clock            = 1'b0;
   logic                   reset            = 1'b1;
   logic                   req_valid        = 1'b0;
   logic                   req_ready;
   logic [CMD_BITS-1:0]    req_cmd          = '0;
   logic [KEY_W-1:0]       req_entry_key    = '0;
   logic [PRIO_BITS-1:0]   req_new_priority = '0;
   logic                   rsp_valid;
   logic                   rsp_ready        = 1'b0;
   logic [STATUS_BITS-1:0] rsp_status;
   logic [KEY_W-1:0]       rsp_served_key;
   logic [PRIO_BITS-1:0]   rsp_served_priority;
   logic [OCC_W-1:0]       rsp_occupancy;

   always #(HALF_CLK) clock = ~clock;

   three_level_priority_fifo_table_unit #(
      .ENTRIES    (NUM_SLOTS),
      .KEY_BITS   (KEY_W),
      .STAMP_BITS (STAMP_W)
   ) dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_cmd             (req_cmd),
      .req_entry_key       (req_entry_key),
      .req_new_priority    (req_new_priority),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_status          (rsp_status),
      .rsp_served_key      (rsp_served_key),
      .rsp_served_priority (rsp_served_priority),
      .rsp_occupancy       (rsp_occupancy)
   );

   // ---------------------------------------------------------------------
   // table model: shadow copy of slots, stamps and occupancy
   // ---------------------------------------------------------------------
   logic               slot_used [NUM_SLOTS];
   logic [KEY_W-1:0]   slot_key_m [NUM_SLOTS];
   logic [PRIO_BITS-1:0] slot_level_m [NUM_SLOTS];
   logic [STAMP_W-1:0] slot_stamp_m [NUM_SLOTS];
   logic [STAMP_W-1:0] arrivals;
   int                 live_entries;

   reply_type predicted_rsp_q [$];
   int     error_count    = 0;
   int     send_idle_pct  = 0;
   int     recv_stall_pct = 0;
   logic [KEY_W-1:0] key_pool [8];

   initial begin
      for (int i = 0; i < NUM_SLOTS; i++) slot_used[i] = 1'b0;
      arrivals     = '0;
      live_entries = 0;
   end

   // Executes one command word against the shadow table and returns the
   // word the block must answer with. Ages are counter minus stamp, mod 2^32.
   function automatic reply_type apply_command(logic [CMD_BITS-1:0] cmd,
                                               logic [KEY_W-1:0] key,
                                               logic [PRIO_BITS-1:0] level);
      reply_type        r;
      int               pick;
      logic [STAMP_W-1:0] age_i;
      logic [STAMP_W-1:0] age_p;
      r    = '0;
      r.status = STATUS_OK;
      pick = -1;
      case (cmd)
         CMD_INSERT: begin
            for (int i = 0; i < NUM_SLOTS; i++)
               if (!slot_used[i] && pick < 0) pick = i;
            if (pick < 0) begin
               r.status = STATUS_FULL;
            end else begin
               slot_used[pick]    = 1'b1;
               slot_key_m[pick]   = key;
               slot_level_m[pick] = PRIO_LOW;
               slot_stamp_m[pick] = arrivals;
               arrivals           = arrivals + 1'b1;
               live_entries++;
            end
         end
         CMD_SET_PRIO: begin
            // oldest entry with this key; absence beats the bad-code check
            for (int i = 0; i < NUM_SLOTS; i++) begin
               if (slot_used[i] && slot_key_m[i] == key) begin
                  age_i = arrivals - slot_stamp_m[i];
                  if (pick >= 0) age_p = arrivals - slot_stamp_m[pick];
                  if (pick < 0 || age_i > age_p) pick = i;
               end
            end
            if (pick < 0) r.status = STATUS_NOT_FOUND;
            else if (level == PRIO_INVALID) r.status = STATUS_BAD_PRIO;
            else slot_level_m[pick] = level;
         end
         CMD_SERVE: begin
            // best level first, oldest on ties, lower slot on equal age
            for (int i = 0; i < NUM_SLOTS; i++) begin
               if (slot_used[i]) begin
                  age_i = arrivals - slot_stamp_m[i];
                  if (pick >= 0) age_p = arrivals - slot_stamp_m[pick];
                  if (pick < 0 || slot_level_m[i] < slot_level_m[pick] ||
                      (slot_level_m[i] == slot_level_m[pick] && age_i > age_p))
                     pick = i;
               end
            end
            if (pick < 0) begin
               r.status = STATUS_EMPTY;
            end else begin
               r.key           = slot_key_m[pick];
               r.level         = slot_level_m[pick];
               slot_used[pick] = 1'b0;
               live_entries--;
            end
         end
         default: ;  // unused code: no state change, status ok
      endcase
      r.occ = live_entries[OCC_W-1:0];
      return r;
   endfunction

   function automatic void report_failure(string msg);
      error_count++;
      if (error_count <= MAX_REPORT) $display("ERROR @%0t: %s", $realtime, msg);
   endfunction

   // ---------------------------------------------------------------------
   // result side: random back-pressure, check every accepted word
   // ---------------------------------------------------------------------
   always @(negedge clock) begin
      rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
   end

   always @(posedge clock) begin : rsp_check
      reply_type want;
      reply_type seen;
      if (!reset && rsp_valid && rsp_ready) begin
         seen = '{rsp_status, rsp_served_key, rsp_served_priority, rsp_occupancy};
         if (predicted_rsp_q.size() == 0) begin
            report_failure($sformatf("unexpected rsp word st=%0d key=%h lvl=%0d occ=%0d",
                                     seen.status, seen.key, seen.level, seen.occ));
         end else begin
            want = predicted_rsp_q.pop_front();
            if (seen.status !== want.status || seen.key !== want.key ||
                seen.level !== want.level || seen.occ !== want.occ)
               report_failure($sformatf(
                  "rsp mismatch exp st/key/lvl/occ %0d/%h/%0d/%0d got %0d/%h/%0d/%0d",
                  want.status, want.key, want.level, want.occ,
                  seen.status, seen.key, seen.level, seen.occ));
         end
      end
   end

   // ---------------------------------------------------------------------
   // request side
   // ---------------------------------------------------------------------
   // Entered and left on a falling edge. Random idle cycles first, then
   // valid holds with a stable payload until the accepting rising edge.
   task automatic send_word(logic [CMD_BITS-1:0] cmd, logic [KEY_W-1:0] key,
                            logic [PRIO_BITS-1:0] level);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid        <= 1'b1;
      req_cmd          <= cmd;
      req_entry_key    <= key;
      req_new_priority <= level;
      do @(posedge clock); while (!req_ready);
      predicted_rsp_q.push_back(apply_command(cmd, key, level));
      @(negedge clock);
   endtask

   // hold the sender off until every outstanding word has come back
   task automatic wait_for_results();
      req_valid <= 1'b0;
      while (predicted_rsp_q.size() != 0) @(negedge clock);
   endtask

   // ---------------------------------------------------------------------
   // tests
   // ---------------------------------------------------------------------
   // empty table: serve, lookups that miss (bad code too), unused command
   task automatic test_empty_table();
      send_word(CMD_SERVE, 16'h0000, TB_PRIO_HIGH);
      send_word(CMD_SET_PRIO, 16'hFFFF, TB_PRIO_HIGH);
      send_word(CMD_SET_PRIO, 16'h1234, PRIO_INVALID);
      send_word(CMD_UNUSED, 16'hFFFF, PRIO_INVALID);
   endtask

   // fill to full with extreme and duplicate keys, overflow, then check
   // priority order and first-come choice among equal levels and keys
   task automatic test_fill_and_order();
      logic [KEY_W-1:0] k;
      for (int i = 0; i < NUM_SLOTS; i++) begin
         case (i)
            0:       k = 16'h0000;
            1:       k = 16'hFFFF;
            2, 5:    k = 16'hA5A5;
            default: k = {i[3:0], 12'h5A3};
         endcase
         send_word(CMD_INSERT, k, PRIO_INVALID);
      end
      send_word(CMD_INSERT, 16'h1234, TB_PRIO_HIGH);     // full
      send_word(CMD_SET_PRIO, 16'hA5A5, TB_PRIO_HIGH);   // oldest namesake only
      send_word(CMD_SET_PRIO, 16'hFFFF, PRIO_INVALID);   // present key, bad code
      send_word(CMD_SET_PRIO, 16'hFFFF, TB_PRIO_MED);
      send_word(CMD_SERVE, 16'h0000, TB_PRIO_HIGH);      // A5A5 at high
      send_word(CMD_SERVE, 16'h0000, TB_PRIO_HIGH);      // FFFF at medium
      send_word(CMD_INSERT, 16'h0F0F, TB_PRIO_MED);      // reuses a freed slot, newest
      send_word(CMD_SERVE, 16'h0000, TB_PRIO_HIGH);      // oldest low, not the refill
      send_word(CMD_UNUSED, 16'h5555, TB_PRIO_MED);
   endtask

   // Mostly keys from a small pool so lookups hit and namesakes pile up;
   // a quarter fully random keys for bit coverage and misses.
   task automatic test_random_traffic(int count, int insert_pct, int idle_pct,
                                      int stall_pct);
      int               r;
      logic [CMD_BITS-1:0] cmd;
      logic [KEY_W-1:0]  key;
      send_idle_pct  = idle_pct;
      recv_stall_pct = stall_pct;
      for (int i = 0; i < 8; i++) key_pool[i] = KEY_W'($urandom);
      for (int n = 0; n < count; n++) begin
         r = $urandom_range(99);
         if (r < insert_pct) cmd = CMD_INSERT;
         else if (r < insert_pct + 25) cmd = CMD_SET_PRIO;
         else if (r < 97) cmd = CMD_SERVE;
         else cmd = CMD_UNUSED;
         if ($urandom_range(3) == 0) key = KEY_W'($urandom);
         else key = key_pool[$urandom_range(7)];
         send_word(cmd, key, PRIO_BITS'($urandom_range(3)));
      end
      wait_for_results();
   endtask

   // ---------------------------------------------------------------------
   // sequence
   // ---------------------------------------------------------------------
   initial begin
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_empty_table();
      test_fill_and_order();
      wait_for_results();

      test_random_traffic(275, 55, 0, 0);    // fills, hits full often
      test_random_traffic(275, 30, 75, 0);   // drains, hits empty often
      test_random_traffic(275, 45, 0, 75);
      test_random_traffic(275, 40, 10, 10);

      req_valid <= 1'b0;
      while (predicted_rsp_q.size() != 0) @(negedge clock);
      repeat (NUM_SLOTS + 8) @(negedge clock);
      if (predicted_rsp_q.size() != 0)
         report_failure($sformatf("%0d rsp words never arrived", predicted_rsp_q.size()));

      if (error_count == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

   // watchdog, far beyond the slowest legal run
   initial begin
      #4_000_000;
      $display("status: fail");
      $finish;
   end

endmodule

FILE: three_level_priority_fifo_table_unit.f
+incdir+sv
sv/tlpf_pkg.sv
sv/tlpf_ram.sv
sv/three_level_priority_fifo_table_unit.sv
tb/tb_three_level_priority_fifo_table_unit.sv
